[hw/rtl/sbd_pkg.sv]
// Shared types, codes and permutation tables for the sub-block deinterleaver.
package sbd_pkg;

    localparam int MAX_BLOCK = 8192;
    localparam int CC_STRIDE = 3;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_CC  = 2'd0;
    localparam t_mode MODE_TC  = 2'd1;
    localparam t_mode MODE_TC2 = 2'd2;
    localparam t_mode MODE_RSV = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODE       = 2'd0;
    localparam t_cfg_idx CFG_BLOCK_SIZE = 2'd1;
    localparam t_cfg_idx CFG_CC_OFFSET  = 2'd2;
    localparam t_cfg_idx CFG_CC_COUNT   = 2'd3;

    typedef struct packed {
        logic signed [7:0] soft_value;
        logic              start_req;
    } t_in_item;

    typedef struct packed {
        logic        [14:0] dest_address;
        logic signed [7:0]  out_value;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic step;
        logic from_input;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic emit;
    } t_dp_status;

    localparam logic [4:0] CC_PERM [32] = '{
        5'd1, 5'd17, 5'd9, 5'd25, 5'd5, 5'd21, 5'd13, 5'd29,
        5'd3, 5'd19, 5'd11, 5'd27, 5'd7, 5'd23, 5'd15, 5'd31,
        5'd0, 5'd16, 5'd8, 5'd24, 5'd4, 5'd20, 5'd12, 5'd28,
        5'd2, 5'd18, 5'd10, 5'd26, 5'd6, 5'd22, 5'd14, 5'd30
    };

    localparam logic [4:0] TC_PERM [32] = '{
        5'd0, 5'd16, 5'd8, 5'd24, 5'd4, 5'd20, 5'd12, 5'd28,
        5'd2, 5'd18, 5'd10, 5'd26, 5'd6, 5'd22, 5'd14, 5'd30,
        5'd1, 5'd17, 5'd9, 5'd25, 5'd5, 5'd21, 5'd13, 5'd29,
        5'd3, 5'd19, 5'd11, 5'd27, 5'd7, 5'd23, 5'd15, 5'd31
    };

endpackage

[hw/rtl/subblock_deinterleaver.sv]
// Top level of the 32-column sub-block deinterleaver address generator.
//
// Input channel: one soft value per transfer; start_req on a transfer latches the
// configured block size and restarts the column-by-column matrix walk at that item.
// Output channel: destination address, the soft value unchanged and a last flag.
// Configuration: write enable, register index and 14-bit data, taken at once.
// A result is in the output register in the cycle after its input transfer;
// in convolutional mode each null position in front of the item is stepped over
// first (null positions lie in the first matrix row only, so at most 31 per block).
// Throughput: one item per cycle while no null position is skipped and the output
// is not stalled, set by the datapath walk and the one-entry output register.
// Turbo null positions and items while the walk is finished take a transfer
// and give no result.
// Reset: walk finished, output empty; inputs are taken and dropped until a start.
// When the receiver stalls, the full output register holds its result and input
// ready falls until the result is transferred.
module subblock_deinterleaver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  sbd_pkg::t_cfg_idx    i_cfg_index,
    input  logic [13:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sbd_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sbd_pkg::t_out_item   o_out_data
);

    sbd_pkg::t_dp_cmd    cmd;
    sbd_pkg::t_dp_status status;

    sbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sbd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

[hw/rtl/sbd_ctrl.sv]
// Handshake controller: input acceptance, null-skip sequencing and output valid.
module sbd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  sbd_pkg::t_dp_status   i_status,
    output sbd_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic {
        S_RUN,
        S_SKIP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign o_in_ready     = (r_state == S_RUN) && (!r_out_valid || i_out_ready);
    assign accept         = i_in_valid && o_in_ready;
    assign o_cmd.step       = accept || (r_state == S_SKIP);
    assign o_cmd.from_input = accept;
    assign o_out_valid    = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = (r_out_valid && !i_out_ready) || i_status.emit;
        case (r_state)
            S_RUN: begin
                if (accept && i_status.skip) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!i_status.skip) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/sbd_datapath.sv]
// Datapath: configuration registers, matrix walk, null detection and address generation.
module sbd_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  sbd_pkg::t_cfg_idx     i_cfg_index,
    input  logic [13:0]           i_cfg_data,
    input  sbd_pkg::t_dp_cmd      i_cmd,
    input  sbd_pkg::t_in_item     i_in_data,
    output sbd_pkg::t_dp_status   o_status,
    output sbd_pkg::t_out_item    o_out_data
);

    sbd_pkg::t_mode     r_mode;
    logic [13:0]        r_block_size;
    logic [1:0]         r_cc_offset;
    logic [13:0]        r_cc_count;

    logic [4:0]         r_col;
    logic [7:0]         r_row;
    logic [13:0]        r_taken;
    logic [8:0]         r_rows;
    logic [4:0]         r_nulls;
    logic               r_finished;
    logic signed [7:0]  r_hold;
    sbd_pkg::t_out_item r_out;

    logic [4:0]         n_col;
    logic [7:0]         n_row;
    logic [13:0]        n_taken;
    logic               n_finished;

    logic               fresh;
    logic [13:0]        d_cl;
    logic [8:0]         cfg_rows;
    logic [4:0]         cfg_nulls;
    logic [4:0]         e_col;
    logic [7:0]         e_row;
    logic [13:0]        e_taken;
    logic [8:0]         e_rows;
    logic [4:0]         e_nulls;
    logic               e_finished;
    sbd_pkg::t_mode     m;
    logic               is_cc;
    logic [4:0]         perm_sel;
    logic [13:0]        kp;
    logic [12:0]        idx_base;
    logic [13:0]        idx_inc;
    logic [12:0]        idx;
    logic               null_here;
    logic [8:0]         row_inc;
    logic               row_wrap;
    logic               ended;
    logic [31:0]        colhas;
    logic [31:0]        wrapcol;
    logic [9:0]         row2;
    logic               inrest;
    logic [31:0]        above;
    logic               later;
    logic [13:0]        cnt;
    logic [13:0]        taken_inc;
    logic               active;
    logic               skip;
    logic               emit;
    logic               last;
    logic [12:0]        rel;
    logic [14:0]        dest;
    logic signed [7:0]  value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sbd_pkg::MODE_CC;
            r_block_size <= 14'd1;
            r_cc_offset  <= 2'd0;
            r_cc_count   <= 14'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbd_pkg::CFG_MODE:       r_mode       <= i_cfg_data[1:0];
                sbd_pkg::CFG_BLOCK_SIZE: r_block_size <= i_cfg_data;
                sbd_pkg::CFG_CC_OFFSET:  r_cc_offset  <= i_cfg_data[1:0];
                sbd_pkg::CFG_CC_COUNT:   r_cc_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_block_size == 14'd0) begin
            d_cl = 14'd1;
        end else if (r_block_size > 14'(sbd_pkg::MAX_BLOCK)) begin
            d_cl = 14'(sbd_pkg::MAX_BLOCK);
        end else begin
            d_cl = r_block_size;
        end
    end

    assign cfg_rows  = 9'((15'(d_cl) + 15'd31) >> 5);
    assign cfg_nulls = 5'd0 - d_cl[4:0];

    assign fresh      = i_cmd.from_input && i_in_data.start_req;
    assign e_col      = fresh ? 5'd0  : r_col;
    assign e_row      = fresh ? 8'd0  : r_row;
    assign e_taken    = fresh ? 14'd0 : r_taken;
    assign e_rows     = fresh ? cfg_rows  : r_rows;
    assign e_nulls    = fresh ? cfg_nulls : r_nulls;
    assign e_finished = fresh ? 1'b0 : r_finished;

    assign m     = (r_mode == sbd_pkg::MODE_RSV) ? sbd_pkg::MODE_TC : r_mode;
    assign is_cc = (m == sbd_pkg::MODE_CC);

    assign perm_sel = is_cc ? sbd_pkg::CC_PERM[e_col] : sbd_pkg::TC_PERM[e_col];
    assign kp       = {e_rows, 5'd0};
    assign idx_base = {e_row, perm_sel};
    assign idx_inc  = 14'(idx_base) + 14'd1;

    always_comb begin
        if (m == sbd_pkg::MODE_TC2) begin
            idx = (idx_inc == kp) ? 13'd0 : 13'(idx_inc);
        end else begin
            idx = idx_base;
        end
    end

    assign null_here = idx < 13'(e_nulls);
    assign row_inc   = 9'(e_row) + 9'd1;
    assign row_wrap  = (row_inc == e_rows);
    assign ended     = row_wrap && (e_col == 5'd31);

    always_comb begin
        logic [4:0] p;
        logic [5:0] v;
        logic       nn0;
        logic       tail;
        for (int c = 0; c < 32; c++) begin
            p = is_cc ? sbd_pkg::CC_PERM[c] : sbd_pkg::TC_PERM[c];
            v = {1'b0, p} + ((m == sbd_pkg::MODE_TC2) ? 6'd1 : 6'd0);
            if (v == 6'd32 && e_rows == 9'd1) begin
                v = 6'd0;
            end
            nn0 = v >= {1'b0, e_nulls};
            wrapcol[c] = (m == sbd_pkg::MODE_TC2) && (sbd_pkg::TC_PERM[c] == 5'd31)
                         && (e_nulls != 5'd0);
            tail = (e_rows >= 9'd3) || ((e_rows == 9'd2) && !wrapcol[c]);
            colhas[c] = nn0 || tail;
        end
    end

    assign row2   = 10'(e_row) + 10'd2;
    assign inrest = (row2 < 10'(e_rows)) || ((row2 == 10'(e_rows)) && !wrapcol[e_col]);
    assign above  = 32'hFFFF_FFFE << e_col;
    assign later  = inrest || (|(colhas & above));

    assign cnt       = (r_cc_count == 14'd0) ? 14'd1 : r_cc_count;
    assign taken_inc = e_taken + 14'd1;

    assign active = i_cmd.step && !e_finished;
    assign skip   = active && is_cc && null_here && !ended;
    assign emit   = active && !null_here;
    assign last   = is_cc ? ((taken_inc >= cnt) || !later) : !later;
    assign rel    = idx - 13'(e_nulls);
    assign dest   = is_cc ? (15'(sbd_pkg::CC_STRIDE) * 15'(rel) + 15'(r_cc_offset))
                          : 15'(rel);
    assign value  = i_cmd.from_input ? i_in_data.soft_value : r_hold;

    always_comb begin
        n_col      = e_col;
        n_row      = e_row;
        n_taken    = e_taken;
        n_finished = e_finished;
        if (active) begin
            n_row = row_wrap ? 8'd0 : 8'(row_inc);
            if (row_wrap && !ended) begin
                n_col = e_col + 5'd1;
            end
            if (is_cc) begin
                if (null_here) begin
                    n_finished = ended;
                end else begin
                    n_taken    = taken_inc;
                    n_finished = last;
                end
            end else begin
                n_finished = ended;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= 5'd0;
            r_row      <= 8'd0;
            r_taken    <= 14'd0;
            r_rows     <= 9'd1;
            r_nulls    <= 5'd31;
            r_finished <= 1'b1;
        end else if (i_cmd.step) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_taken    <= n_taken;
            r_rows     <= e_rows;
            r_nulls    <= e_nulls;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.from_input) begin
            r_hold <= i_in_data.soft_value;
        end
        if (emit) begin
            r_out.dest_address <= dest;
            r_out.out_value    <= value;
            r_out.last         <= last;
        end
    end

    assign o_status.skip = skip;
    assign o_status.emit = emit;
    assign o_out_data    = r_out;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the sub-block deinterleaver address generator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_TARGET = 1150;
    localparam int SETTLE      = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_index = CFG_MODE;
    logic [13:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;

    subblock_deinterleaver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // register mirror and matrix walk state
    logic [1:0]  reg_mode = MODE_CC;
    logic [13:0] reg_size = 14'd1;
    logic [1:0]  reg_offset = 2'd0;
    logic [13:0] reg_count = 14'd1;
    logic [4:0]  walk_col = '0;
    logic [7:0]  walk_row = '0;
    logic [13:0] taken_cnt = '0;
    logic [8:0]  row_total = 9'd1;
    logic [4:0]  null_total = 5'd31;
    bit          walk_done = 1'b1;

    t_in_item  soft_backlog [$];
    t_out_item due_placements [$];
    logic      in_taken = 1'b0;
    int        mismatches = 0;
    int        soft_taken = 0;
    int        quiet_cycles = 0;
    int        items_planned = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stretch_left = 0;
    int        stall_pct = 0;
    int        hold_left = 0;
    int        long_holds = 0;

    function automatic void latch_size();
        int d;
        d = reg_size;
        if (d == 0) d = 1;
        if (d > MAX_BLOCK) d = MAX_BLOCK;
        row_total = 9'((d + 31) / 32);
        null_total = 5'((32 * int'(row_total) - d) & 31);
    endfunction

    function automatic int position(logic [1:0] m, int col, int row);
        int idx;
        if (m == MODE_CC) return int'(CC_PERM[col]) + 32 * row;
        idx = int'(TC_PERM[col]) + 32 * row;
        if (m == MODE_TC2) begin
            idx++;
            if (idx >= 32 * int'(row_total)) idx -= 32 * int'(row_total);
        end
        return idx;
    endfunction

    // advance one position; true when the matrix is exhausted
    function automatic bit step_walk();
        if (int'(walk_row) + 1 >= int'(row_total)) begin
            walk_row = '0;
            if (walk_col == 5'd31) return 1'b1;
            walk_col++;
        end else begin
            walk_row++;
        end
        return 1'b0;
    endfunction

    function automatic bit nonnull_ahead(logic [1:0] m);
        int c, r;
        c = walk_col;
        r = walk_row;
        forever begin
            r++;
            if (r >= int'(row_total)) begin
                r = 0;
                if (c >= 31) return 1'b0;
                c++;
            end
            if (position(m, c, r) >= int'(null_total)) return 1'b1;
        end
    endfunction

    function automatic bit place_soft_value(input t_in_item it, output t_out_item res);
        logic [1:0] m;
        int idx, cnt;
        bit is_last, emit;
        m = (reg_mode == MODE_RSV) ? MODE_TC : reg_mode;
        res = '0;
        if (it.start_req) begin
            latch_size();
            walk_col = '0;
            walk_row = '0;
            taken_cnt = '0;
            walk_done = 1'b0;
        end
        if (walk_done) return 1'b0;
        if (m == MODE_CC) begin
            cnt = (reg_count == 0) ? 1 : int'(reg_count);
            while (position(m, walk_col, walk_row) < int'(null_total)) begin
                if (step_walk()) begin
                    walk_done = 1'b1;
                    return 1'b0;
                end
            end
            idx = position(m, walk_col, walk_row);
            res.dest_address = 15'(CC_STRIDE * (idx - int'(null_total)) + int'(reg_offset));
            taken_cnt++;
            is_last = (int'(taken_cnt) >= cnt) || !nonnull_ahead(m);
            void'(step_walk());
            if (is_last) walk_done = 1'b1;
        end else begin
            idx = position(m, walk_col, walk_row);
            emit = idx >= int'(null_total);
            is_last = emit && !nonnull_ahead(m);
            if (step_walk()) walk_done = 1'b1;
            if (!emit) return 1'b0;
            res.dest_address = 15'(idx - int'(null_total));
        end
        res.out_value = it.soft_value;
        res.last = is_last;
        return 1'b1;
    endfunction

    function automatic int block_span(logic [1:0] m, logic [13:0] size, logic [13:0] count);
        int d, c;
        d = (size == 0) ? 1 : ((size > MAX_BLOCK) ? MAX_BLOCK : int'(size));
        c = (count == 0) ? 1 : int'(count);
        if (m == MODE_CC) return (c < d) ? c : d;
        return 32 * ((d + 31) / 32);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (soft_backlog.size() != 0) begin
                in_valid <= 1'b1;
                in_data <= soft_backlog.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (long_holds < 2 && soft_taken > 250 * (long_holds + 1)
                     && soft_backlog.size() >= 20) begin
            long_holds++;
            hold_left = 150;
            out_ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(10, 80);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 70;
                endcase
            end
            stretch_left--;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && o_in_ready;
            if (in_valid && o_in_ready) begin
                soft_taken++;
                if (place_soft_value(in_data, want)) due_placements.push_back(want);
            end
            if (o_out_valid && out_ready) begin
                got = o_out_data;
                if (due_placements.size() == 0) begin
                    $error("unexpected result: dest_address %0d", got.dest_address);
                    mismatches++;
                end else begin
                    want = due_placements.pop_front();
                    if (got.dest_address !== want.dest_address) begin
                        $error("dest_address expected %0d got %0d",
                               want.dest_address, got.dest_address);
                        mismatches++;
                    end
                    if (got.out_value !== want.out_value) begin
                        $error("out_value expected %0d got %0d",
                               want.out_value, got.out_value);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last expected %0d got %0d", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_setting(t_cfg_idx idx, logic [13:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_MODE:       reg_mode = value[1:0];
            CFG_BLOCK_SIZE: reg_size = value;
            CFG_CC_OFFSET:  reg_offset = value[1:0];
            default:        reg_count = value;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (soft_backlog.size() != 0 || in_valid || due_placements.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_soft(logic signed [7:0] value, logic start);
        t_in_item it;
        it.soft_value = value;
        it.start_req = start;
        soft_backlog.push_back(it);
    endtask

    task automatic queue_block(int len, bit with_start, bit noisy);
        for (int k = 0; k < len; k++) begin
            queue_soft(8'($urandom),
                       (k == 0 && with_start) || (noisy && $urandom_range(0, 49) == 0));
        end
    endtask

    task automatic run_phase(logic [1:0] m, logic [13:0] size, logic [1:0] offset,
                             logic [13:0] count, int items, bit resume);
        int span, len, extra, kind, left;
        bit first;
        wait_drained();
        write_setting(CFG_MODE, 14'(m));
        write_setting(CFG_BLOCK_SIZE, size);
        write_setting(CFG_CC_OFFSET, 14'(offset));
        write_setting(CFG_CC_COUNT, count);
        span = block_span(m, size, count);
        left = items;
        first = 1'b1;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            len = (span > 300) ? $urandom_range(20, 300) : span;
            if (kind == 0) len = $urandom_range(1, len);
            extra = (kind == 1) ? $urandom_range(1, 3) : 0;
            queue_block(len + extra, !(first && resume), kind == 2);
            left -= len;
            items_planned += len;
            first = 1'b0;
        end
    endtask

    initial begin
        logic [1:0]  m;
        logic [13:0] size, count;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle before any start, then a one-result block at reset settings
        queue_soft(8'sd127, 1'b0);
        queue_soft(-8'sd128, 1'b1);
        queue_soft(8'sd0, 1'b0);

        run_phase(MODE_CC, 14'd0, 2'd3, 14'd0, 3, 1'b0);
        run_phase(MODE_CC, 14'h3FFF, 2'd0, 14'd2, 6, 1'b0);
        run_phase(MODE_CC, 14'd8192, 2'd2, 14'd8192, 150, 1'b0);
        run_phase(MODE_CC, 14'd33, 2'd1, 14'h3FFF, 70, 1'b0);
        run_phase(MODE_CC, 14'd40, 2'd2, 14'd5, 20, 1'b0);
        run_phase(MODE_RSV, 14'd1, 2'd1, 14'd1, 40, 1'b0);
        run_phase(MODE_TC2, 14'd1, 2'd0, 14'd0, 40, 1'b0);
        run_phase(MODE_TC, 14'd32, 2'd3, 14'h3FFF, 70, 1'b0);
        run_phase(MODE_TC2, 14'd33, 2'd0, 14'd1, 100, 1'b1);
        run_phase(MODE_TC2, 14'd8192, 2'd0, 14'd0, 150, 1'b0);

        while (items_planned < ITEM_TARGET) begin
            m = 2'($urandom_range(0, 3));
            size = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 160));
            count = ($urandom_range(0, 5) == 0) ? 14'($urandom)
                                                : 14'($urandom_range(0, int'(size) + 4));
            run_phase(m, size, 2'($urandom_range(0, 3)), count, $urandom_range(40, 120),
                      $urandom_range(0, 3) == 0);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
